>>> src/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stream pattern masker.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int PAT_BYTES   = 16;
  localparam int WIN_DEPTH   = 17;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

  typedef enum logic [1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spm_item_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_MASK = 4'b0100,
    ST_DONE = 4'b1000
  } scan_state_t;

endpackage

>>> src/spm_queue.sv
// ----------------------------------------------------------------------------
// spm_queue
// Input front: accepts stream items into a two-entry queue for the scanner.
// ----------------------------------------------------------------------------
module spm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] in_byte
  input  logic               s_tlast,
  output logic               item_valid,
  output spm_pkg::spm_item_t item,
  input  logic               item_pop
);
  import spm_pkg::*;

  spm_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !item_pop) begin
        count <= count + 2'd1;
      end else if (!push && item_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{data: s_tdata, last: s_tlast};
    end
  end

endmodule

>>> src/spm_scan.sv
// ----------------------------------------------------------------------------
// spm_scan
// Back end: holds the pending window, matches it against the pattern and
// releases bytes or asterisks through a held stage and an output register.
// ----------------------------------------------------------------------------
module spm_scan #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  input  spm_pkg::spm_item_t                      item,
  output logic                                    item_pop,
  input  logic [spm_pkg::PAT_BYTES-1:0][7:0]      pattern,
  input  logic [spm_pkg::CNT_W-1:0]               pat_len,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [7:0]                              m_tdata,   // [7:0] out_byte
  output logic                                    m_tlast,
  output logic                                    m_tuser    // [0] line_done
);
  import spm_pkg::*;

  localparam logic [CNT_W-1:0] RES_CAP = CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0] WIN_CAP = CNT_W'(WIN_DEPTH);

  scan_state_t        state;
  scan_state_t        state_next;
  logic [7:0]         win [WIN_DEPTH];
  logic [CNT_W-1:0]   wcnt;
  logic [CNT_W-1:0]   ocnt;
  logic [CNT_W-1:0]   mask_left;
  logic               cur_last;
  logic               held_valid;
  logic [7:0]         held_byte;
  logic               out_valid;
  logic [7:0]         out_data;
  logic               out_last;
  logic               out_user;

  logic [MAX_PATTERN-1:0] lane_ok;
  logic               match;
  logic               out_free;
  logic               can_emit;
  logic               at_cap;
  logic               take_byte;
  logic               start_mask;
  logic               emit;
  logic [7:0]         emit_val;
  logic               shift;
  logic               mask_step;
  logic               flush;
  logic               load_out;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      lane_ok[i] = !((CNT_W'(i) < wcnt) && (CNT_W'(i) < pat_len)) ||
                   (win[i] == pattern[i]);
    end
  end

  assign match      = &lane_ok;
  assign out_free   = !out_valid || m_tready;
  assign can_emit   = !held_valid || out_free;
  assign at_cap     = (ocnt == RES_CAP);
  assign take_byte  = (pat_len == '0) || !match || ((wcnt < pat_len) && cur_last);
  assign start_mask = !take_byte && (wcnt >= pat_len);

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    emit       = 1'b0;
    emit_val   = win[0];
    shift      = 1'b0;
    mask_step  = 1'b0;
    flush      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((wcnt == '0) || at_cap) begin
          state_next = ST_DONE;
        end else if (take_byte) begin
          if (can_emit) begin
            emit  = 1'b1;
            shift = 1'b1;
          end
        end else if (start_mask) begin
          state_next = ST_MASK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MASK: begin
        emit_val = MASK_CHAR;
        if (at_cap) begin
          mask_step = 1'b1;
        end else if (can_emit) begin
          mask_step = 1'b1;
          emit      = 1'b1;
        end
        shift = mask_step;
        if (mask_step && (mask_left == CNT_W'(1))) begin
          state_next = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!held_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flush      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign load_out = (emit && held_valid) || flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wcnt       <= '0;
      ocnt       <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (item_pop) begin
        wcnt <= wcnt + CNT_W'(1);
        ocnt <= '0;
      end else begin
        if (shift) begin
          wcnt <= wcnt - CNT_W'(1);
        end
        if (emit) begin
          ocnt <= ocnt + CNT_W'(1);
        end
      end
      if (emit) begin
        held_valid <= 1'b1;
      end else if (flush) begin
        held_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      win[wcnt] <= item.data;
      cur_last  <= item.last;
    end else if (shift) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
    if (state == ST_SCAN && start_mask && !take_byte && wcnt != '0 && !at_cap) begin
      mask_left <= pat_len;
    end else if (mask_step) begin
      mask_left <= mask_left - CNT_W'(1);
    end
    if (emit) begin
      held_byte <= emit_val;
    end
    if (load_out) begin
      out_data <= held_byte;
      out_last <= flush;
      out_user <= flush && cur_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;
  assign m_tuser  = out_user;

`ifndef SYNTHESIS
  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    ocnt <= RES_CAP) else $error("result count above cap");

  a_window_cap: assert property (@(posedge clk) disable iff (rst)
    wcnt <= WIN_CAP) else $error("window count above depth");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_MASK |-> mask_left != '0) else $error("mask run with zero length");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !held_valid) else $error("held result left at idle");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    item_pop |=> (state == ST_SCAN) && !held_valid) else $error("pop outside idle");
`endif

endmodule

>>> src/stream_pattern_masker.sv
// ----------------------------------------------------------------------------
// stream_pattern_masker
// Masks every non-overlapping occurrence of a configured byte pattern in a
// line with asterisks, holding back bytes that may still start a match.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    tdata[7:0] in_byte, tlast line_last
// m_*       out        m_tvalid/m_tready    tdata[7:0] out_byte, tlast run_last,
//                                           tuser[0] line_done
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The scanner pops an item in idle, releases bytes in scan and asterisks in
// mask, then ends in done; it takes no new item until it is back in idle.
// Reset is synchronous and empties the pending window and the queue.
// The two-entry input queue and the output register let each side stall alone.
// ----------------------------------------------------------------------------
module stream_pattern_masker #(
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,
  output logic        m_tuser,    // [0] line_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import spm_pkg::*;

  logic [63:0]      pat_low;
  logic [63:0]      pat_high;
  logic [CNT_W-1:0] pat_len;
  logic [CNT_W-1:0] act_len;

  logic [PAT_BYTES-1:0][7:0] pattern;
  logic                      item_valid;
  spm_item_t                 item;
  logic                      item_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAT_LOW:  pat_low  <= cfg_data;
        CFG_PAT_HIGH: pat_high <= cfg_data;
        CFG_PAT_LEN:  pat_len  <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign act_len = (pat_len > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : pat_len;
  assign pattern = {pat_high, pat_low};

  spm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  spm_scan #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .pattern    (pattern),
    .pat_len    (act_len),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

>>> test/stream_pattern_masker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_pattern_masker_tb
// Drives text lines through the masker and checks every released byte, with
// its run and line markers, against a built-in model of the masking window.
// A short directed table comes first, then random phases. Each phase sets a
// new pattern, sometimes in the middle of a line, and sends pattern copies,
// partial prefixes and noise bytes. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module stream_pattern_masker_tb;
  import spm_pkg::*;

  localparam int          RAND_ITEMS  = 130;
  localparam int          QUIET_AFTER = 100;
  localparam int          DRAIN       = 64;
  localparam int unsigned LIMIT       = 400_000;
  localparam int          DIR_ROWS    = 27;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_index_t idx;
    logic [63:0] val;
    logic [7:0] in_byte;
    logic       line_last;
    logic       typed;
    logic [7:0] exp_byte;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       line_done;
  } masked_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] in_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;            // [7:0] out_byte
  logic        m_tlast;
  logic        m_tuser;            // [0] line_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PAT_LOW;
  logic [63:0] cfg_data = 64'd0;

  masked_t     masked_q[$];
  int          mismatch_cnt = 0;
  int unsigned cyc = 0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  int          stall_left = 0;

  // window model
  logic [63:0] pat_lo = 64'd0;
  logic [63:0] pat_hi = 64'd0;
  logic [4:0]  pat_len = 5'd0;
  logic [7:0]  held [PAT_BYTES];
  int          held_cnt = 0;
  logic [7:0]  step_byte [MAX_RESULTS];
  int          step_cnt;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h00, 1'b0, 1'b1, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{ROW_CFG,  CFG_PAT_LOW,  64'hF0E1_D2C3_B4A5_6261, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_HIGH, 64'h0F1E_2D3C_4B5A_6978, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_LEN,  64'd2,                 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h62, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h78, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b1, 1'b1, 8'h61},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h0A, 1'b0, 1'b1, 8'h0A},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h62, 1'b1, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_LOW,  64'h6161_6161_6161_6161, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_HIGH, 64'h6161_6161_6161_6161, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_LEN,  64'd31,                8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_LEN,  64'd2,                 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h62, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h61, 1'b0, 1'b0, 8'h00},
    '{ROW_CFG,  CFG_PAT_LEN,  64'd0,                 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM, CFG_PAT_LOW,  64'd0,                 8'h63, 1'b1, 1'b0, 8'h00}
  };

  stream_pattern_masker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] pat_byte(input int i);
    if (i < 8) begin
      return pat_lo[8*i +: 8];
    end
    return pat_hi[8*(i-8) +: 8];
  endfunction

  // Scan the held bytes plus the new one; fill step_byte with released bytes.
  task automatic mask_step(input logic [7:0] in_byte, input logic line_last);
    logic [7:0] win [PAT_BYTES+1];
    int n, pos, len, rem, k, i;
    bit hit;
    n = held_cnt;
    for (i = 0; i < n; i++) win[i] = held[i];
    win[n] = in_byte;
    n++;
    len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
    pos = 0;
    step_cnt = 0;
    while (pos < n && step_cnt < MAX_RESULTS) begin
      rem = n - pos;
      if (len == 0) begin
        step_byte[step_cnt] = win[pos];
        step_cnt++;
        pos++;
      end else begin
        k = (rem < len) ? rem : len;
        hit = 1'b1;
        for (i = 0; i < k; i++) begin
          if (win[pos+i] != pat_byte(i)) hit = 1'b0;
        end
        if (hit && rem >= len) begin
          for (i = 0; i < len && step_cnt < MAX_RESULTS; i++) begin
            step_byte[step_cnt] = MASK_CHAR;
            step_cnt++;
          end
          pos += len;
        end else if (hit && !line_last) begin
          break;
        end else begin
          step_byte[step_cnt] = win[pos];
          step_cnt++;
          pos++;
        end
      end
    end
    held_cnt = 0;
    while (pos < n && held_cnt < PAT_BYTES) begin
      held[held_cnt] = win[pos];
      held_cnt++;
      pos++;
    end
  endtask

  task automatic send_item(input logic [7:0] in_byte, input logic line_last,
                           input logic typed, input logic [7:0] exp_byte);
    int i;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= in_byte;
    s_tlast  <= line_last;
    do @(posedge clk); while (!s_tready);
    mask_step(in_byte, line_last);
    if (typed) begin
      masked_q.push_back('{exp_byte, 1'b1, line_last});
    end else begin
      for (i = 0; i < step_cnt; i++) begin
        masked_q.push_back('{step_byte[i], i == step_cnt - 1,
                             (i == step_cnt - 1) && line_last});
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PAT_LOW:  pat_lo = val;
      CFG_PAT_HIGH: pat_hi = val;
      CFG_PAT_LEN:  pat_len = val[4:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 16);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    masked_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (masked_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected item: actual byte=%h run_last=%b line_done=%b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = masked_q.pop_front();
        if (m_tdata !== want.out_byte || m_tlast !== want.run_last ||
            m_tuser !== want.line_done) begin
          mismatch_cnt++;
          $display("%0t: mismatch: exp byte=%h last=%b done=%b, act byte=%h last=%b done=%b",
                   $time, want.out_byte, want.run_last, want.line_done,
                   m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stim
    logic [63:0] lo, hi;
    logic [4:0]  plen;
    logic [7:0]  pb;
    int eff, n_items, chunk, run_len, i, j, sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (j = 0; j < DIR_ROWS; j++) begin
      if (dir_tab[j].kind == ROW_CFG) begin
        write_reg(dir_tab[j].idx, dir_tab[j].val);
      end else begin
        send_item(dir_tab[j].in_byte, dir_tab[j].line_last, dir_tab[j].typed,
                  dir_tab[j].exp_byte);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: plen = 5'd0;
        1: plen = 5'd16;
        2: plen = 5'($urandom_range(17, 31));
        default: plen = 5'($urandom_range(1, 5));
      endcase
      write_reg(CFG_PAT_LOW, lo);
      write_reg(CFG_PAT_HIGH, hi);
      write_reg(CFG_PAT_LEN, {59'd0, plen});
      eff = (plen > 5'd16) ? 16 : int'(plen);
      if (sent >= QUIET_AFTER) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      n_items = $urandom_range(12, 28) + eff;
      while (n_items > 0) begin
        chunk = $urandom_range(0, 9);
        if (eff > 0 && chunk < 5) begin
          run_len = eff;
        end else if (eff > 1 && chunk < 7) begin
          run_len = $urandom_range(1, eff - 1);
        end else begin
          run_len = 0;
        end
        for (i = 0; i < run_len; i++) begin
          if (i < 8) begin
            pb = lo[8*i +: 8];
          end else begin
            pb = hi[8*(i-8) +: 8];
          end
          send_item(pb, $urandom_range(0, 15) == 0, 1'b0, 8'h00);
          n_items--;
          sent++;
        end
        if (chunk >= 5) begin
          send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, 1'b0, 8'h00);
          n_items--;
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
